// ===== src/spt_pkg.sv =====
// Package for the Stanley path tracker: widths, fixed-point constants,
// the CORDIC arctangent table, register indexes and the sequencer states.
// Depends on nothing; src/stanley_path_tracker.sv imports it.
`default_nettype none

package spt_pkg;

   localparam int DEFAULT_PATH_POINTS = 1024;

   localparam int POS_W      = 32;
   localparam int ANG_W      = 16;
   localparam int SPD_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int CNT_W      = 11;
   localparam int IDX_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int POINT_W    = 2 * POS_W + ANG_W;

   localparam int CW        = 56;
   localparam int ZW        = 21;
   localparam int TRIG_W    = 19;
   localparam int STEP_W    = 4;
   localparam int CORDIC_STEPS = 16;
   localparam int MUL_A_W   = 19;
   localparam int MUL_B_W   = 36;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int DIST_W    = 64;

   localparam logic signed [ZW-1:0] PI_Q16      = 21'sd205887;
   localparam logic signed [ZW-1:0] HALF_PI_Q16 = 21'sd102944;
   localparam logic signed [ZW-1:0] TWO_PI_Q16  = 21'sd411774;
   localparam logic signed [16:0]   PI_Q12      = 17'sd12868;
   localparam logic signed [16:0]   TWO_PI_Q12  = 17'sd25736;
   localparam logic signed [CW-1:0] CORDIC_K    = 56'sd652032875;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STEER_GAIN  = 3'd0,
      CSR_VEL_GAIN    = 3'd1,
      CSR_TARGET_SPD  = 3'd2,
      CSR_WHEELBASE   = 3'd3,
      CSR_PATH_POINTS = 3'd4
   } csr_index_type;

   typedef enum logic [15:0] {
      ST_IDLE    = 16'h0001,
      ST_CORDIC  = 16'h0002,
      ST_SC_OUT  = 16'h0004,
      ST_AXLE_C  = 16'h0008,
      ST_AXLE_S  = 16'h0010,
      ST_SCAN0   = 16'h0020,
      ST_SCAN    = 16'h0040,
      ST_CHECK   = 16'h0080,
      ST_DXY     = 16'h0100,
      ST_HD      = 16'h0200,
      ST_M_CDY   = 16'h0400,
      ST_E_CALC  = 16'h0800,
      ST_M_GE    = 16'h1000,
      ST_AT_INIT = 16'h2000,
      ST_FINISH  = 16'h4000,
      ST_OUT     = 16'h8000
   } state_type;

   // Arctangent of 2^-step in Q16 radians.
   function automatic logic signed [ZW-1:0] cordic_atan(input logic [STEP_W-1:0] step);
      case (step)
         4'd0:    return 21'sd51472;
         4'd1:    return 21'sd30385;
         4'd2:    return 21'sd16055;
         4'd3:    return 21'sd8150;
         4'd4:    return 21'sd4091;
         4'd5:    return 21'sd2047;
         4'd6:    return 21'sd1024;
         4'd7:    return 21'sd512;
         4'd8:    return 21'sd256;
         4'd9:    return 21'sd128;
         4'd10:   return 21'sd64;
         4'd11:   return 21'sd32;
         4'd12:   return 21'sd16;
         4'd13:   return 21'sd8;
         4'd14:   return 21'sd4;
         4'd15:   return 21'sd2;
         default: return 21'sd0;
      endcase
   endfunction

endpackage

`default_nettype wire

// ===== src/stanley_path_tracker.sv =====
// Stanley path tracker: path point store, nearest point scan, shared CORDIC
// and the steering and speed command arithmetic. Depends on spt_pkg.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | func, point_index, pos_x, pos_y, heading, speed
//  rsp     | out       | rsp_valid/rsp_ready  | accel_cmd, steer_cmd, arrived, nearest_index
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A load beat writes one path point to the store. A control beat for n path points runs
// 16 CORDIC rotations for sin and cos, one store read per point through a
// five-stage distance pipeline, the multiplier states and 16 CORDIC vectoring steps.
// The path store is a single-port-read memory, which sets the scan at one point a cycle.
// Reset is synchronous and clears control state only; the store is not cleared.
// A finished result waits in ST_OUT until the output register is free; no request is taken meanwhile.
`default_nettype none

module stanley_path_tracker
   import spt_pkg::*;
#(
   parameter int MAX_PATH_POINTS = DEFAULT_PATH_POINTS
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_func,
   input  wire logic [IDX_W-1:0]             req_point_index,
   input  wire logic signed [POS_W-1:0]      req_pos_x,
   input  wire logic signed [POS_W-1:0]      req_pos_y,
   input  wire logic signed [ANG_W-1:0]      req_heading,
   input  wire logic signed [SPD_W-1:0]      req_speed,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [SPD_W-1:0]           rsp_accel_cmd,
   output logic signed [ANG_W-1:0]           rsp_steer_cmd,
   output logic                              rsp_arrived,
   output logic [IDX_W-1:0]                  rsp_nearest_index,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int AddrW = $clog2(MAX_PATH_POINTS);
   localparam logic signed [POS_W+1:0] PosMax = 34'sd2147483647;
   localparam logic signed [POS_W+1:0] PosMin = -34'sd2147483648;
   localparam logic signed [39:0]      CmdMax = 40'sd32767;
   localparam logic signed [39:0]      CmdMin = -40'sd32768;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
      if (v > PosMax) return PosMax[POS_W-1:0];
      if (v < PosMin) return PosMin[POS_W-1:0];
      return v[POS_W-1:0];
   endfunction

   function automatic logic signed [15:0] sat_cmd(input logic signed [39:0] v);
      if (v > CmdMax) return CmdMax[15:0];
      if (v < CmdMin) return CmdMin[15:0];
      return v[15:0];
   endfunction

   // The difference of two angles lies within three turns of the wrapped range.
   function automatic logic signed [16:0] wrap_q12(input logic signed [16:0] a);
      logic signed [16:0] t;
      t = a;
      for (int k = 0; k < 3; k++) begin
         if (t > PI_Q12) t = t - TWO_PI_Q12;
         else if (t < -PI_Q12) t = t + TWO_PI_Q12;
      end
      return t;
   endfunction

   // Path store: {heading, y, x} per point.
   logic [POINT_W-1:0] path_mem [MAX_PATH_POINTS];
   logic [POINT_W-1:0] rd_data_ff;
   logic [AddrW-1:0]   rd_addr, mem_wa;
   logic               mem_we;

   state_type state_ff, state_in;
   logic [GAIN_W-1:0]        steer_gain_ff, steer_gain_in;
   logic [GAIN_W-1:0]        vel_gain_ff, vel_gain_in;
   logic signed [SPD_W-1:0]  target_speed_ff, target_speed_in;
   logic [GAIN_W-1:0]        wheelbase_ff, wheelbase_in;
   logic [CNT_W-1:0]         path_points_ff, path_points_in;
   logic [CNT_W-1:0]         tracking_ff, tracking_in;
   logic                     arrived_flag_ff, arrived_flag_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     p1_vld_ff, p1_vld_in, p2_vld_ff, p2_vld_in;
   logic                     p3_vld_ff, p3_vld_in, p4_vld_ff, p4_vld_in;

   logic signed [POS_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0]  yaw_ff, yaw_in;
   logic signed [SPD_W-1:0]  v_ff, v_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic signed [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0]     cz_ff, cz_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     rot_mode_ff, rot_mode_in, flip_ff, flip_in;
   logic signed [TRIG_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in, pa_ff, pa_in;
   logic signed [POS_W-1:0]  fx_ff, fx_in, fy_ff, fy_in;
   logic [CNT_W-1:0]         scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0]         p1_idx_ff, p1_idx_in, p2_idx_ff, p2_idx_in;
   logic [CNT_W-1:0]         p3_idx_ff, p3_idx_in, p4_idx_ff, p4_idx_in;
   logic [POS_W-1:0]         p2_ax_ff, p2_ax_in, p2_ay_ff, p2_ay_in;
   logic [DIST_W-1:0]        p3_sx_ff, p3_sx_in, p3_sy_ff, p3_sy_in;
   logic [DIST_W-1:0]        p4_d_ff, p4_d_in;
   logic [CNT_W-1:0]         best_ff, best_in;
   logic [DIST_W-1:0]        best_d_ff, best_d_in;
   logic signed [POS_W:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic signed [16:0]       the_ff, the_in;
   logic signed [MUL_B_W-1:0] e_ff, e_in;
   logic signed [15:0]       res_accel_ff, res_accel_in, res_steer_ff, res_steer_in;
   logic                     res_arr_ff, res_arr_in;
   logic [IDX_W-1:0]         res_idx_ff, res_idx_in;
   logic signed [15:0]       rsp_accel_ff, rsp_accel_in, rsp_steer_ff, rsp_steer_in;
   logic                     rsp_arr_ff, rsp_arr_in;
   logic [IDX_W-1:0]         rsp_idx_ff, rsp_idx_in;

   // Datapath intermediates.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [CW-1:0]      sh_x, sh_y, nx, ny, xs, ys, vx, vy;
   logic signed [ZW-1:0]      at, nz, ang0, ang1;
   logic                      y_pos, dir;
   logic signed [POS_W-1:0]   px, py;
   logic signed [ANG_W-1:0]   ph;
   logic signed [POS_W:0]     ddx, ddy;
   logic [DIST_W:0]           dsum;
   logic [CNT_W-1:0]          n_req;
   logic                      issue, load_out, req_hs;
   logic signed [ZW-1:0]      td_wide;
   logic signed [17:0]        steer_sum;

   assign px = rd_data_ff[POS_W-1:0];
   assign py = rd_data_ff[2*POS_W-1:POS_W];
   assign ph = rd_data_ff[POINT_W-1:2*POS_W];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_hs    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign load_out  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign issue     = (state_ff == ST_SCAN) && (scan_cnt_ff < n_ff);

   assign n_req = ({21'b0, path_points_ff} > 32'(MAX_PATH_POINTS)) ?
                  CNT_W'(MAX_PATH_POINTS) : path_points_ff;

   // Shared CORDIC step: rotation steers by the angle sign, vectoring by the y sign.
   assign sh_x  = cx_ff >>> step_ff;
   assign sh_y  = cy_ff >>> step_ff;
   assign at    = cordic_atan(step_ff);
   assign y_pos = !cy_ff[CW-1] && (cy_ff != '0);
   assign dir   = rot_mode_ff ? !cz_ff[ZW-1] : !y_pos;
   assign nx    = dir ? cx_ff - sh_y : cx_ff + sh_y;
   assign ny    = dir ? cy_ff + sh_x : cy_ff - sh_x;
   assign nz    = dir ? cz_ff - at : cz_ff + at;
   assign xs    = flip_ff ? -cx_ff : cx_ff;
   assign ys    = flip_ff ? -cy_ff : cy_ff;

   assign ang0 = {{(ZW-ANG_W-4){req_heading[ANG_W-1]}}, req_heading, 4'b0000};
   assign ang1 = (ang0 > PI_Q16) ? ang0 - TWO_PI_Q16 :
                 (ang0 < -PI_Q16) ? ang0 + TWO_PI_Q16 : ang0;

   assign ddx = (POS_W+1)'(fx_ff) - (POS_W+1)'(px);
   assign ddy = (POS_W+1)'(fy_ff) - (POS_W+1)'(py);
   assign dsum = {1'b0, p3_sx_ff} + {1'b0, p3_sy_ff};

   assign vx = {{(CW-32){v_ff[SPD_W-1]}}, v_ff, 16'b0};
   assign vy = CW'(prod_ff);
   assign td_wide   = (cz_ff + ZW'(8)) >>> 4;
   assign steer_sum = 18'(the_ff) + 18'($signed(td_wide[16:0]));

   always_comb begin
      case (state_ff)
         ST_AXLE_C: begin
            mul_a = $signed({3'b000, wheelbase_ff});
            mul_b = MUL_B_W'(cos_ff);
         end
         ST_AXLE_S: begin
            mul_a = $signed({3'b000, wheelbase_ff});
            mul_b = MUL_B_W'(sin_ff);
         end
         ST_HD: begin
            mul_a = sin_ff;
            mul_b = MUL_B_W'(dx_ff);
         end
         ST_M_CDY: begin
            mul_a = cos_ff;
            mul_b = MUL_B_W'(dy_ff);
         end
         ST_E_CALC: begin
            mul_a = $signed({3'b000, vel_gain_ff});
            mul_b = MUL_B_W'(17'(target_speed_ff) - 17'(v_ff));
         end
         ST_M_GE: begin
            mul_a = $signed({3'b000, steer_gain_ff});
            mul_b = e_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      case (state_ff)
         ST_SCAN:  rd_addr = AddrW'(scan_cnt_ff);
         ST_CHECK: rd_addr = AddrW'(best_ff);
         default:  rd_addr = AddrW'(tracking_ff);
      endcase
   end

   assign mem_we = req_hs && !req_func && ({22'b0, req_point_index} < 32'(MAX_PATH_POINTS));
   assign mem_wa = AddrW'(req_point_index);

   always_comb begin
      state_in        = state_ff;
      steer_gain_in   = steer_gain_ff;
      vel_gain_in     = vel_gain_ff;
      target_speed_in = target_speed_ff;
      wheelbase_in    = wheelbase_ff;
      path_points_in  = path_points_ff;
      tracking_in     = tracking_ff;
      arrived_flag_in = arrived_flag_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      x_in = x_ff;  y_in = y_ff;  yaw_in = yaw_ff;  v_in = v_ff;  n_in = n_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;  step_in = step_ff;
      rot_mode_in = rot_mode_ff;  flip_in = flip_ff;
      cos_in = cos_ff;  sin_in = sin_ff;  prod_in = prod_ff;  pa_in = pa_ff;
      fx_in = fx_ff;  fy_in = fy_ff;  scan_cnt_in = scan_cnt_ff;
      best_in = best_ff;  best_d_in = best_d_ff;
      dx_in = dx_ff;  dy_in = dy_ff;  the_in = the_ff;  e_in = e_ff;
      res_accel_in = res_accel_ff;  res_steer_in = res_steer_ff;
      res_arr_in = res_arr_ff;  res_idx_in = res_idx_ff;
      rsp_accel_in = rsp_accel_ff;  rsp_steer_in = rsp_steer_ff;
      rsp_arr_in = rsp_arr_ff;  rsp_idx_in = rsp_idx_ff;

      // Distance pipeline: read, absolute difference, squares, saturating sum, compare.
      p1_vld_in = issue;
      p1_idx_in = scan_cnt_ff;
      p2_vld_in = p1_vld_ff;
      p2_idx_in = p1_idx_ff;
      p2_ax_in  = ddx[POS_W] ? POS_W'(-ddx) : ddx[POS_W-1:0];
      p2_ay_in  = ddy[POS_W] ? POS_W'(-ddy) : ddy[POS_W-1:0];
      p3_vld_in = p2_vld_ff;
      p3_idx_in = p2_idx_ff;
      p3_sx_in  = p2_ax_ff * p2_ax_ff;
      p3_sy_in  = p2_ay_ff * p2_ay_ff;
      p4_vld_in = p3_vld_ff;
      p4_idx_in = p3_idx_ff;
      p4_d_in   = dsum[DIST_W] ? '1 : dsum[DIST_W-1:0];
      if (p4_vld_ff && ((p4_idx_ff == '0) || (p4_d_ff < best_d_ff))) begin
         best_in   = p4_idx_ff;
         best_d_in = p4_d_ff;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEER_GAIN:  steer_gain_in   = csr_data;
            CSR_VEL_GAIN:    vel_gain_in     = csr_data;
            CSR_TARGET_SPD:  target_speed_in = $signed(csr_data);
            CSR_WHEELBASE:   wheelbase_in    = csr_data;
            CSR_PATH_POINTS: path_points_in  = csr_data[CNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_hs && !req_func) begin
               if (req_point_index == '0) begin
                  tracking_in     = '0;
                  arrived_flag_in = 1'b0;
               end
            end else if (req_hs) begin
               x_in   = req_pos_x;
               y_in   = req_pos_y;
               yaw_in = req_heading;
               v_in   = req_speed;
               n_in   = n_req;
               if (n_req == '0) begin
                  arrived_flag_in = 1'b1;
                  res_arr_in      = 1'b1;
                  res_idx_in      = '0;
                  res_accel_in    = '0;
                  res_steer_in    = '0;
                  state_in        = ST_OUT;
               end else begin
                  cx_in       = CORDIC_K;
                  cy_in       = '0;
                  step_in     = '0;
                  rot_mode_in = 1'b1;
                  if (ang1 > HALF_PI_Q16) begin
                     cz_in   = ang1 - PI_Q16;
                     flip_in = 1'b1;
                  end else if (ang1 < -HALF_PI_Q16) begin
                     cz_in   = ang1 + PI_Q16;
                     flip_in = 1'b1;
                  end else begin
                     cz_in   = ang1;
                     flip_in = 1'b0;
                  end
                  state_in = ST_CORDIC;
               end
            end
         end
         ST_CORDIC: begin
            cx_in   = nx;
            cy_in   = ny;
            cz_in   = nz;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = rot_mode_ff ? ST_SC_OUT : ST_FINISH;
            end
         end
         ST_SC_OUT: begin
            cos_in   = TRIG_W'(xs >>> 14);
            sin_in   = TRIG_W'(ys >>> 14);
            state_in = ST_AXLE_C;
         end
         ST_AXLE_C: begin
            prod_in  = mul_p;
            state_in = ST_AXLE_S;
         end
         ST_AXLE_S: begin
            fx_in    = sat_pos((POS_W+2)'(x_ff) + (POS_W+2)'(prod_ff >>> 8));
            prod_in  = mul_p;
            state_in = ST_SCAN0;
         end
         ST_SCAN0: begin
            fy_in       = sat_pos((POS_W+2)'(y_ff) + (POS_W+2)'(prod_ff >>> 8));
            scan_cnt_in = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (issue) begin
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end else if (!p1_vld_ff && !p2_vld_ff && !p3_vld_ff && !p4_vld_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_idx_in = best_ff[IDX_W-1:0];
            if (best_ff == n_ff - CNT_W'(1)) begin
               arrived_flag_in = 1'b1;
               res_arr_in      = 1'b1;
               res_accel_in    = '0;
               res_steer_in    = '0;
               state_in        = ST_OUT;
            end else begin
               if (best_ff >= tracking_ff) tracking_in = best_ff;
               state_in = ST_DXY;
            end
         end
         ST_DXY: begin
            dx_in    = ddx;
            dy_in    = ddy;
            state_in = ST_HD;
         end
         ST_HD: begin
            the_in   = wrap_q12(17'(ph) - 17'(yaw_ff));
            prod_in  = mul_p;
            state_in = ST_M_CDY;
         end
         ST_M_CDY: begin
            pa_in    = prod_ff;
            prod_in  = mul_p;
            state_in = ST_E_CALC;
         end
         ST_E_CALC: begin
            e_in     = MUL_B_W'((pa_ff - prod_ff) >>> 16);
            prod_in  = mul_p;
            state_in = ST_M_GE;
         end
         ST_M_GE: begin
            res_accel_in = sat_cmd(40'(prod_ff >>> 8));
            prod_in      = mul_p;
            state_in     = ST_AT_INIT;
         end
         ST_AT_INIT: begin
            rot_mode_in = 1'b0;
            step_in     = '0;
            if (vx == '0 && vy == '0) begin
               cz_in    = '0;
               state_in = ST_FINISH;
            end else begin
               if (vx[CW-1]) begin
                  cx_in = -vx;
                  cy_in = -vy;
                  cz_in = vy[CW-1] ? -PI_Q16 : PI_Q16;
               end else begin
                  cx_in = vx;
                  cy_in = vy;
                  cz_in = '0;
               end
               state_in = ST_CORDIC;
            end
         end
         ST_FINISH: begin
            res_steer_in = sat_cmd(40'(steer_sum));
            res_arr_in   = 1'b0;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_accel_in = res_accel_ff;
               rsp_steer_in = res_steer_ff;
               rsp_arr_in   = res_arr_ff;
               rsp_idx_in   = res_idx_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) path_mem[mem_wa] <= {req_heading, req_pos_y, req_pos_x};
      rd_data_ff <= path_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         steer_gain_ff   <= 16'd128;
         vel_gain_ff     <= 16'd256;
         target_speed_ff <= '0;
         wheelbase_ff    <= 16'd256;
         path_points_ff  <= '0;
         tracking_ff     <= '0;
         arrived_flag_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         p1_vld_ff       <= 1'b0;
         p2_vld_ff       <= 1'b0;
         p3_vld_ff       <= 1'b0;
         p4_vld_ff       <= 1'b0;
      end else begin
         state_ff        <= state_in;
         steer_gain_ff   <= steer_gain_in;
         vel_gain_ff     <= vel_gain_in;
         target_speed_ff <= target_speed_in;
         wheelbase_ff    <= wheelbase_in;
         path_points_ff  <= path_points_in;
         tracking_ff     <= tracking_in;
         arrived_flag_ff <= arrived_flag_in;
         rsp_valid_ff    <= rsp_valid_in;
         p1_vld_ff       <= p1_vld_in;
         p2_vld_ff       <= p2_vld_in;
         p3_vld_ff       <= p3_vld_in;
         p4_vld_ff       <= p4_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;  y_ff <= y_in;  yaw_ff <= yaw_in;  v_ff <= v_in;  n_ff <= n_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  cz_ff <= cz_in;  step_ff <= step_in;
      rot_mode_ff <= rot_mode_in;  flip_ff <= flip_in;
      cos_ff <= cos_in;  sin_ff <= sin_in;  prod_ff <= prod_in;  pa_ff <= pa_in;
      fx_ff <= fx_in;  fy_ff <= fy_in;  scan_cnt_ff <= scan_cnt_in;
      p1_idx_ff <= p1_idx_in;  p2_idx_ff <= p2_idx_in;
      p3_idx_ff <= p3_idx_in;  p4_idx_ff <= p4_idx_in;
      p2_ax_ff <= p2_ax_in;  p2_ay_ff <= p2_ay_in;
      p3_sx_ff <= p3_sx_in;  p3_sy_ff <= p3_sy_in;  p4_d_ff <= p4_d_in;
      best_ff <= best_in;  best_d_ff <= best_d_in;
      dx_ff <= dx_in;  dy_ff <= dy_in;  the_ff <= the_in;  e_ff <= e_in;
      res_accel_ff <= res_accel_in;  res_steer_ff <= res_steer_in;
      res_arr_ff <= res_arr_in;  res_idx_ff <= res_idx_in;
      rsp_accel_ff <= rsp_accel_in;  rsp_steer_ff <= rsp_steer_in;
      rsp_arr_ff <= rsp_arr_in;  rsp_idx_ff <= rsp_idx_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accel_cmd     = rsp_accel_ff;
   assign rsp_steer_cmd     = rsp_steer_ff;
   assign rsp_arrived       = rsp_arr_ff;
   assign rsp_nearest_index = rsp_idx_ff;

`ifndef ASSERT_OFF
   a_tracking_in_range: assert property (@(posedge clock) disable iff (reset)
      ({21'b0, tracking_ff} < 32'(MAX_PATH_POINTS)))
      else $error("tracking index beyond the path store");

   a_arrival_flag: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) && rsp_arr_ff) |-> arrived_flag_ff)
      else $error("arrival result without the arrived flag");

   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> !(p1_vld_ff || p2_vld_ff || p3_vld_ff || p4_vld_ff))
      else $error("nearest point checked before the distance pipeline drained");
`endif

endmodule

`default_nettype wire
